/* design/icseq_pkg.sv */
// Shared types, codes and defaults for the I2C master command sequencer.
package icseq_pkg;

    localparam int RING_DEPTH_DEFAULT = 16;
    localparam int TAG_COUNT_DEFAULT  = 16;

    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_MARKER = 2'd2;
    localparam logic [1:0] KIND_EVENT  = 2'd3;

    localparam logic [7:0] STATUS_MASK    = 8'hF8;
    localparam logic [7:0] ST_START       = 8'h08;
    localparam logic [7:0] ST_RESTART     = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK  = 8'h18;
    localparam logic [7:0] ST_ADDR_W_NACK = 8'h20;
    localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
    localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
    localparam logic [7:0] ST_ADDR_R_ACK  = 8'h40;
    localparam logic [7:0] ST_ADDR_R_NACK = 8'h48;
    localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
    localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

    localparam logic [7:0] CMD_RESTART = 8'hFE;
    localparam logic [7:0] CMD_STOP    = 8'hFF;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] dev_addr;
        logic [7:0] reg_index;
        logic [7:0] data_byte;
        logic [3:0] dest_tag;
        logic [7:0] bus_status;
        logic [7:0] rx_byte;
    } req_item_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       send_start;
        logic       send_stop;
        logic       ack_enable;
        logic       irq_enable;
        logic       clear_flag;
        logic       read_valid;
        logic [3:0] read_tag;
        logic [7:0] read_data;
    } rsp_item_t;

endpackage

/* design/icseq_stream_if.sv */
// Valid/ready stream channel carrying one payload item per transfer.
interface icseq_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* design/i2c_master_command_sequencer_unit.sv */
// I2C master command sequencer: command/tag rings and bus status decode.
//
// Usage:
//   req  : host items and bus status events (icseq_pkg::req_item_t).
//          Kinds write, read and marker push bytes into the command ring
//          (a read also pushes a tag); start, data-write, data-read and
//          addr-write-ACK statuses pop a command byte, data-read also a tag.
//   rsp  : one control item per recognized status event
//          (icseq_pkg::rsp_item_t). Host items and unknown statuses give
//          no transfer on rsp.
//   Throughput: one req transfer per cycle, sustained, while rsp drains.
//   A status event accepted on req goes to the read stage, then to the output register that drives rsp.
//   The command ring is four one-write-port banks plus up to three tail
//   registers (for depths not a multiple of four), so the up to four bytes
//   of one host item land in the same cycle; ring reads are registered at the
//   accept edge, then the decode feeds the output register.
//   Reset: all ring pointers and valid flags clear; ring contents are not
//   cleared and hold nothing meaningful until written.
//   Stall: while rsp is held the output register keeps its item, one more
//   event waits in the read stage, and req.ready drops only when both are
//   occupied.
module i2c_master_command_sequencer_unit #(
    parameter int RING_DEPTH = icseq_pkg::RING_DEPTH_DEFAULT,
    parameter int TAG_COUNT  = icseq_pkg::TAG_COUNT_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    icseq_stream_if.sink    req,
    icseq_stream_if.source  rsp
);
    import icseq_pkg::*;

    // ring geometry
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int BANK_ROWS  = RING_DEPTH / 4;
    localparam int RING_BODY  = BANK_ROWS * 4;
    localparam int TAIL_N     = RING_DEPTH - RING_BODY;
    localparam int TAIL_SLOTS = (TAIL_N > 0) ? TAIL_N : 1;
    localparam int ROW_W      = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
    localparam int TAG_AW     = $clog2(TAG_COUNT);

    // event classes held in the read stage
    localparam logic [2:0] CLS_START   = 3'd0;
    localparam logic [2:0] CLS_WR_ACK  = 3'd1;
    localparam logic [2:0] CLS_DATA_RD = 3'd2;
    localparam logic [2:0] CLS_ADDR_RD = 3'd3;
    localparam logic [2:0] CLS_NACK    = 3'd4;

    function automatic logic [RING_AW-1:0] ring_add(input logic [RING_AW-1:0] ptr,
                                                    input logic [2:0] step);
        logic [RING_AW:0] sum;
        sum = {1'b0, ptr} + (RING_AW+1)'(step);
        if (sum >= (RING_AW+1)'(RING_DEPTH))
            sum = sum - (RING_AW+1)'(RING_DEPTH);
        return sum[RING_AW-1:0];
    endfunction

    function automatic logic in_tail(input logic [RING_AW-1:0] pos);
        return {1'b0, pos} >= (RING_AW+1)'(RING_BODY);
    endfunction

    function automatic logic [ROW_W-1:0] row_of(input logic [RING_AW-1:0] pos);
        logic [RING_AW-1:0] shifted;
        shifted = pos >> 2;
        return shifted[ROW_W-1:0];
    endfunction

    // pointers
    logic [RING_AW-1:0] cmd_wr_ptr_reg, cmd_wr_ptr_next;
    logic [RING_AW-1:0] cmd_rd_ptr_reg;
    logic [TAG_AW-1:0]  tag_wr_ptr_reg, tag_rd_ptr_reg;
    logic [TAG_AW-1:0]  tag_wr_pos, tag_rd_pos;

    // read stage and output register
    logic               s1_valid_reg;
    logic [2:0]         s1_cls_reg;
    logic [7:0]         s1_rx_reg;
    logic [1:0]         s1_bank_sel_reg;
    logic               s1_from_tail_reg;
    logic [7:0]         bank_rd_reg [4];
    logic [7:0]         tail_rd_reg;
    logic [3:0]         tag_rd_reg;
    logic               out_valid_reg;
    rsp_item_t          out_reg;

    logic               accept, s1_adv;
    logic               has_result, cmd_pop, tag_pop, tag_push;
    logic [2:0]         evt_cls;
    logic [7:0]         status_m;
    logic [RING_AW-1:0] rd_pos;

    // pushes of one host item
    logic [2:0]         push_n;
    logic [7:0]         push_byte [4];
    logic [RING_AW-1:0] push_pos [4];

    logic               bank_we [4];
    logic [ROW_W-1:0]   bank_waddr [4];
    logic [7:0]         bank_wdata [4];

    logic [7:0]         tail_mem [TAIL_SLOTS];
    logic [TAG_AW-1:0]  tag_unused_guard;
    logic [3:0]         tag_mem [TAG_COUNT];

    logic [7:0]         cmd_byte;
    rsp_item_t          res;

    // handshake: read stage moves on when the output register is free
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !s1_valid_reg || s1_adv;
    assign accept    = req.valid && req.ready;

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // status decode at the accept edge
    assign status_m = req.data.bus_status & STATUS_MASK;

    always_comb
    begin
        has_result = 1'b0;
        cmd_pop    = 1'b0;
        tag_pop    = 1'b0;
        evt_cls    = CLS_NACK;
        if (accept && req.data.kind == KIND_EVENT)
        begin
            unique case (status_m)
                ST_START, ST_RESTART:
                begin
                    has_result = 1'b1;
                    cmd_pop    = 1'b1;
                    evt_cls    = CLS_START;
                end
                ST_ADDR_W_ACK, ST_DATA_W_ACK, ST_DATA_W_NACK:
                begin
                    has_result = 1'b1;
                    cmd_pop    = 1'b1;
                    evt_cls    = CLS_WR_ACK;
                end
                ST_DATA_R_ACK, ST_DATA_R_NACK:
                begin
                    has_result = 1'b1;
                    cmd_pop    = 1'b1;
                    tag_pop    = 1'b1;
                    evt_cls    = CLS_DATA_RD;
                end
                ST_ADDR_R_ACK:
                begin
                    has_result = 1'b1;
                    evt_cls    = CLS_ADDR_RD;
                end
                ST_ADDR_R_NACK, ST_ADDR_W_NACK:
                begin
                    has_result = 1'b1;
                    evt_cls    = CLS_NACK;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign tag_push = accept && req.data.kind == KIND_READ;

    // bytes queued by a host item; the ring advances before each write
    always_comb
    begin
        push_n       = 3'd0;
        push_byte[0] = req.data.dev_addr;
        push_byte[1] = req.data.reg_index;
        push_byte[2] = req.data.data_byte;
        push_byte[3] = req.data.dev_addr + 8'd1;
        if (accept)
        begin
            unique case (req.data.kind)
                KIND_WRITE:
                    push_n = 3'd3;
                KIND_READ:
                begin
                    push_n       = 3'd4;
                    push_byte[2] = CMD_RESTART;
                end
                KIND_MARKER:
                begin
                    push_n       = 3'd1;
                    push_byte[0] = req.data.data_byte;
                end
                KIND_EVENT:
                    push_n = 3'd0;
            endcase
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
            push_pos[j] = ring_add(cmd_wr_ptr_reg, 3'(j + 1));
        cmd_wr_ptr_next = cmd_wr_ptr_reg;
        if (push_n != 3'd0)
            cmd_wr_ptr_next = ring_add(cmd_wr_ptr_reg, push_n);
    end

    // any four ring-consecutive body positions fall in distinct banks
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            bank_we[b]    = 1'b0;
            bank_waddr[b] = '0;
            bank_wdata[b] = '0;
            for (int j = 0; j < 4; j++)
            begin
                if (3'(j) < push_n && !in_tail(push_pos[j])
                    && push_pos[j][1:0] == 2'(b))
                begin
                    bank_we[b]    = 1'b1;
                    bank_waddr[b] = row_of(push_pos[j]);
                    bank_wdata[b] = push_byte[j];
                end
            end
        end
    end

    assign rd_pos = ring_add(cmd_rd_ptr_reg, 3'd1);

    // command ring banks: one write and one registered read per cycle
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [7:0] mem [BANK_ROWS];

        always_ff @(posedge clk)
        begin
            if (bank_we[b])
                mem[bank_waddr[b]] <= bank_wdata[b];
            if (cmd_pop)
                bank_rd_reg[b] <= mem[row_of(rd_pos)];
        end
    end

    // tail entries beyond the last full bank row
    always_ff @(posedge clk)
    begin
        for (int t = 0; t < TAIL_N; t++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                if (3'(j) < push_n
                    && {1'b0, push_pos[j]} == (RING_AW+1)'(RING_BODY + t))
                    tail_mem[t] <= push_byte[j];
            end
        end
        if (cmd_pop)
        begin
            for (int t = 0; t < TAIL_N; t++)
            begin
                if ({1'b0, rd_pos} == (RING_AW+1)'(RING_BODY + t))
                    tail_rd_reg <= tail_mem[t];
            end
        end
    end

    // tag ring
    assign tag_wr_pos = (tag_wr_ptr_reg == TAG_AW'(TAG_COUNT - 1)) ? '0
                        : tag_wr_ptr_reg + TAG_AW'(1);
    assign tag_rd_pos = (tag_rd_ptr_reg == TAG_AW'(TAG_COUNT - 1)) ? '0
                        : tag_rd_ptr_reg + TAG_AW'(1);
    assign tag_unused_guard = tag_wr_pos;

    always_ff @(posedge clk)
    begin
        if (tag_push)
            tag_mem[tag_unused_guard] <= req.data.dest_tag;
        if (tag_pop)
            tag_rd_reg <= tag_mem[tag_rd_pos];
    end

    // read stage payload
    always_ff @(posedge clk)
    begin
        if (accept && has_result)
        begin
            s1_cls_reg       <= evt_cls;
            s1_rx_reg        <= req.data.rx_byte;
            s1_bank_sel_reg  <= rd_pos[1:0];
            s1_from_tail_reg <= in_tail(rd_pos);
        end
        if (s1_adv)
            out_reg <= res;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_wr_ptr_reg <= '0;
            cmd_rd_ptr_reg <= '0;
            tag_wr_ptr_reg <= '0;
            tag_rd_ptr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cmd_wr_ptr_reg <= cmd_wr_ptr_next;
            if (cmd_pop)
                cmd_rd_ptr_reg <= rd_pos;
            if (tag_push)
                tag_wr_ptr_reg <= tag_wr_pos;
            if (tag_pop)
                tag_rd_ptr_reg <= tag_rd_pos;
            if (accept)
                s1_valid_reg <= has_result;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result decode from the popped byte
    assign cmd_byte = s1_from_tail_reg ? tail_rd_reg : bank_rd_reg[s1_bank_sel_reg];

    always_comb
    begin
        res = '0;
        unique case (s1_cls_reg)
            CLS_START:
            begin
                res.tx_valid   = 1'b1;
                res.tx_byte    = cmd_byte;
                res.ack_enable = 1'b1;
                res.irq_enable = 1'b1;
                res.clear_flag = 1'b1;
            end
            CLS_WR_ACK, CLS_DATA_RD:
            begin
                res.ack_enable = 1'b1;
                res.irq_enable = 1'b1;
                priority if (cmd_byte == CMD_STOP)
                    res.send_stop = 1'b1;
                else if (cmd_byte == CMD_RESTART)
                    res.send_start = 1'b1;
                else
                begin
                    res.tx_valid   = 1'b1;
                    res.tx_byte    = cmd_byte;
                    res.clear_flag = 1'b1;
                end
                if (s1_cls_reg == CLS_DATA_RD)
                begin
                    res.read_valid = 1'b1;
                    res.read_tag   = tag_rd_reg;
                    res.read_data  = s1_rx_reg;
                end
            end
            CLS_ADDR_RD:
            begin
                res.irq_enable = 1'b1;
                res.clear_flag = 1'b1;
            end
            CLS_NACK:
            begin
                res.send_stop  = 1'b1;
                res.clear_flag = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
